// ===== design/table_waveform_generator_macros.svh =====
// Assertion macros for the table waveform generator checker.
// No dependencies; included by the checker file only.
`ifndef TABLE_WAVEFORM_GENERATOR_MACROS_SVH
`define TABLE_WAVEFORM_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TWG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TWG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/twg_pkg.sv =====
// Shared types, constants and the divide-by-255 helper for the waveform generator.
// No dependencies; used by twg_sample, twg_period and the top level.
`default_nettype none

package twg_pkg;

   // wave_select codes
   localparam logic [2:0] WAVE_SINE     = 3'd1;
   localparam logic [2:0] WAVE_RAMP     = 3'd2;
   localparam logic [2:0] WAVE_TRIANGLE = 3'd3;
   localparam logic [2:0] WAVE_SQUARE   = 3'd4;
   localparam logic [2:0] WAVE_RESET    = WAVE_SINE;

   localparam logic [7:0] MIDSCALE = 8'h80;

   // period limits
   localparam int SineHi   = 133332;
   localparam int SineLo   = 132;
   localparam int RampHi   = 99999;
   localparam int RampLo   = 99;
   localparam int SquareHi = 799999;
   localparam int SquareLo = 799;

   // span / 255 split into quotient and remainder so that
   // span * level / 255 = level * Q + level * R / 255 exactly
   localparam int SineQ   = (SineHi - SineLo) / 255;
   localparam int SineR   = (SineHi - SineLo) % 255;
   localparam int RampQ   = (RampHi - RampLo) / 255;
   localparam int RampR   = (RampHi - RampLo) % 255;
   localparam int SquareQ = (SquareHi - SquareLo) / 255;
   localparam int SquareR = (SquareHi - SquareLo) % 255;

   // filter band thresholds
   localparam logic [19:0] SINE_BAND1 = 20'd3366;
   localparam logic [19:0] SINE_BAND2 = 20'd336;
   localparam logic [19:0] SINE_BAND3 = 20'd132;
   localparam logic [19:0] RAMP_BAND1 = 20'd2524;
   localparam logic [19:0] RAMP_BAND2 = 20'd252;
   localparam logic [19:0] RAMP_BAND3 = 20'd99;

   localparam logic [19:0] PERIOD_RESET = 20'd15999;

   typedef struct packed {
      logic [3:0] twelve;
      logic [3:0] sixteen;
      logic       two;
   } idx_type;

   // floor(x / 255), exact for x below 65280
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      return t[15:8];
   endfunction

endpackage

`default_nettype wire

// ===== design/twg_sample.sv =====
// Table lookup and amplitude scaling of the DAC sample.
// Depends on twg_pkg (wave codes, idx_type, div255).
`default_nettype none

module twg_sample (
   input  wire logic [2:0]       wave,
   input  wire twg_pkg::idx_type idx,
   input  wire logic [7:0]       level,
   output logic [7:0]            dac
);

   function automatic logic [7:0] sine_at(input logic [3:0] i);
      case (i)
         4'd0:    return 8'h80;
         4'd1:    return 8'hC0;
         4'd2:    return 8'hEE;
         4'd3:    return 8'hFF;
         4'd4:    return 8'hEE;
         4'd5:    return 8'hC0;
         4'd6:    return 8'h80;
         4'd7:    return 8'h40;
         4'd8:    return 8'h12;
         4'd9:    return 8'h00;
         4'd10:   return 8'h12;
         4'd11:   return 8'h40;
         default: return 8'h80;
      endcase
   endfunction

   function automatic logic [7:0] tri_at(input logic [3:0] i);
      case (i)
         4'd0:    return 8'h80;
         4'd1:    return 8'hAB;
         4'd2:    return 8'hD5;
         4'd3:    return 8'hFF;
         4'd4:    return 8'hD5;
         4'd5:    return 8'hAB;
         4'd6:    return 8'h80;
         4'd7:    return 8'h55;
         4'd8:    return 8'h2B;
         4'd9:    return 8'h00;
         4'd10:   return 8'h2B;
         4'd11:   return 8'h55;
         default: return 8'h80;
      endcase
   endfunction

   logic [7:0]  sample;
   logic        known;
   logic [7:0]  diff;
   logic [15:0] prod;
   logic [7:0]  mag;

   always_comb begin
      known  = 1'b1;
      sample = twg_pkg::MIDSCALE;
      case (wave)
         twg_pkg::WAVE_SINE:     sample = sine_at(idx.twelve);
         twg_pkg::WAVE_RAMP:     sample = {idx.sixteen, 4'h0};
         twg_pkg::WAVE_TRIANGLE: sample = tri_at(idx.twelve);
         twg_pkg::WAVE_SQUARE:   sample = {8{idx.two}};
         default:                known  = 1'b0;
      endcase

      if (sample >= twg_pkg::MIDSCALE) begin
         diff = sample - twg_pkg::MIDSCALE;
      end else begin
         diff = twg_pkg::MIDSCALE - sample;
      end
      prod = {8'd0, diff} * {8'd0, level};
      mag  = twg_pkg::div255(prod);

      if (!known) begin
         dac = twg_pkg::MIDSCALE;
      end else if (sample >= twg_pkg::MIDSCALE) begin
         dac = twg_pkg::MIDSCALE + mag;
      end else begin
         dac = twg_pkg::MIDSCALE - mag;
      end
   end

endmodule

`default_nettype wire

// ===== design/twg_period.sv =====
// Timer period from a level, and filter band choice from the current period.
// Depends on twg_pkg (wave codes, limits, band thresholds, div255).
`default_nettype none

module twg_period (
   input  wire logic [2:0]  wave,
   input  wire logic [7:0]  level,
   input  wire logic [19:0] period_now,
   input  wire logic [1:0]  band_now,
   output logic [19:0]      period_calc,
   output logic [1:0]       band_next
);

   function automatic logic [1:0] pick_band(input logic [19:0] t, input logic [19:0] top,
                                            input logic [19:0] b1, input logic [19:0] b2,
                                            input logic [19:0] b3, input logic [1:0] keep);
      if (t <= top && t >= b1) return 2'd1;
      if (t < b1 && t >= b2)   return 2'd2;
      if (t < b2 && t >= b3)   return 2'd3;
      return keep;
   endfunction

   logic [19:0] lo;
   logic [11:0] quo;
   logic [7:0]  rem;
   logic [19:0] coarse;
   logic [15:0] fine_prod;
   logic [7:0]  fine;

   always_comb begin
      lo  = 20'(twg_pkg::SquareLo);
      quo = 12'(twg_pkg::SquareQ);
      rem = 8'(twg_pkg::SquareR);
      case (wave)
         twg_pkg::WAVE_SINE, twg_pkg::WAVE_TRIANGLE: begin
            lo  = 20'(twg_pkg::SineLo);
            quo = 12'(twg_pkg::SineQ);
            rem = 8'(twg_pkg::SineR);
         end
         twg_pkg::WAVE_RAMP: begin
            lo  = 20'(twg_pkg::RampLo);
            quo = 12'(twg_pkg::RampQ);
            rem = 8'(twg_pkg::RampR);
         end
         default: ;
      endcase

      coarse      = {12'd0, level} * {8'd0, quo};
      fine_prod   = {8'd0, level} * {8'd0, rem};
      fine        = twg_pkg::div255(fine_prod);
      period_calc = lo + coarse + {12'd0, fine};

      case (wave)
         twg_pkg::WAVE_SINE, twg_pkg::WAVE_TRIANGLE:
            band_next = pick_band(period_now, 20'(twg_pkg::SineHi), twg_pkg::SINE_BAND1,
                                  twg_pkg::SINE_BAND2, twg_pkg::SINE_BAND3, band_now);
         twg_pkg::WAVE_RAMP:
            band_next = pick_band(period_now, 20'(twg_pkg::RampHi), twg_pkg::RAMP_BAND1,
                                  twg_pkg::RAMP_BAND2, twg_pkg::RAMP_BAND3, band_now);
         default:
            band_next = 2'd0;
      endcase
   end

endmodule

`default_nettype wire

// ===== design/table_waveform_generator.sv =====
// Top level of the table waveform generator: handshakes, state and result register.
// Depends on twg_pkg, twg_sample and twg_period.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  req_    | in        | valid / stall (out) | pot[7:0], sw1_pressed, sw2_pressed
//  rsp_    | out       | valid / stall (in)  | dac_value[7:0], tick_period[19:0],
//          |           |                     | filter_band[1:0]
//  csr_    | in        | valid / ready (out) | wave_select[2:0]
//
// One beat per clock in both directions while neither side stalls; a request beat
// passes the input register, then the result register, on its way to the result port.
// All per-beat work is one pass of combinational logic between those two registers;
// the widest path is the 8x12 period multiply plus its add.
// Reset is synchronous, active high; it empties both registers and restores the state.
// A stalled result holds the result register; the input register still takes one more
// beat, and only then is req_stall raised. csr_ready is always high; the user must
// write wave_select only while the block is idle, which the block does not enforce.
`default_nettype none

module table_waveform_generator (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_pot,
   input  wire logic        req_sw1_pressed,
   input  wire logic        req_sw2_pressed,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_dac_value,
   output logic [19:0]      rsp_tick_period,
   output logic [1:0]       rsp_filter_band,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_wave_select
);

   // configuration
   logic [2:0]  wave_ff, wave_in;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  pot_ff;
   logic        sw1_ff, sw2_ff;

   // generator state
   twg_pkg::idx_type idx_ff, idx_in;
   logic [7:0]  amp_ff, amp_in;
   logic [7:0]  freq_ff, freq_in;
   logic        mode_ff, mode_in;     // 1: pot adjusts frequency
   logic [19:0] period_ff, period_in; // doubles as the result's period field
   logic [1:0]  band_ff, band_in;     // doubles as the result's band field

   // result register
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  dac_ff;

   logic        req_take;
   logic        rsp_take;
   logic        advance;
   logic        wave_known;
   logic        period_update;
   logic [7:0]  scale_level;
   logic [7:0]  period_level;
   logic [7:0]  dac_calc;
   logic [19:0] period_calc;
   logic [1:0]  band_next;

   assign csr_ready = 1'b1;

   // the beat in the input register moves on when the result register is free
   // or is being emptied in this cycle
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = out_valid_ff && !rsp_stall;

   assign rsp_valid       = out_valid_ff;
   assign rsp_dac_value   = dac_ff;
   assign rsp_tick_period = period_ff;
   assign rsp_filter_band = band_ff;

   twg_sample u_sample (
      .wave  (wave_ff),
      .idx   (idx_in),
      .level (scale_level),
      .dac   (dac_calc)
   );

   twg_period u_period (
      .wave        (wave_ff),
      .level       (period_level),
      .period_now  (period_ff),
      .band_now    (band_ff),
      .period_calc (period_calc),
      .band_next   (band_next)
   );

   always_comb begin
      wave_in = wave_ff;
      if (csr_valid && csr_ready) begin
         wave_in = csr_wave_select;
      end

      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end

      // sw2 wins when both are pressed; neither holds the mode
      mode_in = mode_ff;
      if (sw2_ff) begin
         mode_in = 1'b1;
      end else if (sw1_ff) begin
         mode_in = 1'b0;
      end

      // every index steps before use; the twelve-entry one also wraps from stray values
      idx_in.twelve  = (idx_ff.twelve >= 4'd11) ? 4'd0 : idx_ff.twelve + 4'd1;
      idx_in.sixteen = idx_ff.sixteen + 4'd1;
      idx_in.two     = ~idx_ff.two;

      case (wave_ff)
         twg_pkg::WAVE_SINE, twg_pkg::WAVE_RAMP,
         twg_pkg::WAVE_TRIANGLE, twg_pkg::WAVE_SQUARE: wave_known = 1'b1;
         default:                                      wave_known = 1'b0;
      endcase

      if (mode_in) begin
         amp_in        = amp_ff;
         freq_in       = pot_ff;
         scale_level   = amp_ff;
         period_level  = pot_ff;
         period_update = wave_known;
      end else begin
         amp_in        = pot_ff;
         freq_in       = freq_ff;
         scale_level   = pot_ff;
         period_level  = freq_ff;
         period_update = wave_known && (freq_ff != 8'd0);
      end

      period_in = period_update ? period_calc : period_ff;
      band_in   = band_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff      <= twg_pkg::WAVE_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
         amp_ff       <= 8'd0;
         freq_ff      <= 8'd0;
         mode_ff      <= 1'b0;
         period_ff    <= twg_pkg::PERIOD_RESET;
         band_ff      <= 2'd0;
      end else begin
         wave_ff      <= wave_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            idx_ff    <= idx_in;
            amp_ff    <= amp_in;
            freq_ff   <= freq_in;
            mode_ff   <= mode_in;
            period_ff <= period_in;
            band_ff   <= band_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         pot_ff <= req_pot;
         sw1_ff <= req_sw1_pressed;
         sw2_ff <= req_sw2_pressed;
      end
      if (advance) begin
         dac_ff <= dac_calc;
      end
   end

endmodule

`default_nettype wire

// ===== design/twg_checker.sv =====
// Port-level assertions for the table waveform generator, bound to the top level.
// Depends on table_waveform_generator_macros.svh and table_waveform_generator.
`default_nettype none

`include "table_waveform_generator_macros.svh"

module twg_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_dac_value,
   input wire logic [19:0] rsp_tick_period,
   input wire logic [1:0]  rsp_filter_band
);

   // a result beat held by the sink keeps its payload
   `TWG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_dac_value) && $stable(rsp_tick_period) && $stable(rsp_filter_band), "result beat changed under stall")

   // the request side only stalls when the result side does
   `TWG_ASSERT_SAME(a_stall_cause, clock, reset, req_stall, rsp_stall, "request stalled without result stall")

   // an accepted beat reaches the result port if no result stall holds it in the input register
   `TWG_ASSERT_NEXT(a_latency, clock, reset, (req_valid && !req_stall) ##1 !rsp_stall, rsp_valid, "accepted beat did not arrive as a result")

   // the timer reload never leaves the square-wave limit
   `TWG_ASSERT_SAME(a_period_range, clock, reset, rsp_valid, rsp_tick_period <= 20'd799999, "tick period out of range")

endmodule

bind table_waveform_generator twg_checker u_twg_checker (.*);

`default_nettype wire

// ===== dv/twg_tick_checker.sv =====
// Scoreboard for the table waveform generator: watches the request, result and
// register channels, predicts every result beat and compares it field by field.
// Depends on twg_pkg for wave codes, period limits and band thresholds.
module twg_tick_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_pot,
   input  logic        req_sw1_pressed,
   input  logic        req_sw2_pressed,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_dac_value,
   input  logic [19:0] rsp_tick_period,
   input  logic [1:0]  rsp_filter_band,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_wave_select,
   output int          outstanding,
   output int          mismatches
);
   import twg_pkg::*;

   typedef struct packed {
      logic [7:0]  dac;
      logic [19:0] period;
      logic [1:0]  band;
   } tick_result_t;

   tick_result_t pending_ticks[$];

   // generator state as the block should hold it
   logic [2:0]  wave_sel;
   logic [3:0]  idx12;
   logic [3:0]  idx16;
   logic        idx2;
   logic [7:0]  amp_lvl;
   logic [7:0]  freq_lvl;
   logic        freq_mode;
   logic [19:0] period;
   logic [1:0]  band;
   int          beat_no;

   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH %s", $time, what);
      mismatches++;
   endtask

   function automatic logic [7:0] sine_point(input logic [3:0] i);
      case (i)
         4'd0, 4'd6:  return 8'h80;
         4'd1, 4'd5:  return 8'hC0;
         4'd2, 4'd4:  return 8'hEE;
         4'd3:        return 8'hFF;
         4'd7, 4'd11: return 8'h40;
         4'd8, 4'd10: return 8'h12;
         default:     return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] triangle_point(input logic [3:0] i);
      case (i)
         4'd0, 4'd6:  return 8'h80;
         4'd1, 4'd5:  return 8'hAB;
         4'd2, 4'd4:  return 8'hD5;
         4'd3:        return 8'hFF;
         4'd7, 4'd11: return 8'h55;
         4'd8, 4'd10: return 8'h2B;
         default:     return 8'h00;
      endcase
   endfunction

   // outside all three bands the old band is kept
   function automatic logic [1:0] pick_band(input int t, input int lo1, input int hi1,
                                            input int lo2, input int lo3,
                                            input logic [1:0] keep);
      if (t >= lo1 && t <= hi1) return 2'd1;
      if (t < lo1 && t >= lo2) return 2'd2;
      if (t < lo2 && t >= lo3) return 2'd3;
      return keep;
   endfunction

   function automatic logic [19:0] period_for(input int top_p, input int base_p,
                                              input logic [7:0] lvl);
      return 20'(base_p + (top_p - base_p) * int'(lvl) / 255);
   endfunction

   function automatic tick_result_t advance_generator(input logic [7:0] pot,
                                                      input logic sw1, input logic sw2);
      tick_result_t res;
      int          top_p;
      int          base_p;
      logic [7:0]  sample;
      logic [7:0]  level;
      logic        defined;
      top_p   = 0;
      base_p  = 0;
      sample  = MIDSCALE;
      defined = 1'b1;

      if (sw1) freq_mode = 1'b0;
      if (sw2) freq_mode = 1'b1;

      // band comes from the period held before this tick
      case (wave_sel)
         WAVE_SINE, WAVE_TRIANGLE:
            band = pick_band(period, SINE_BAND1, SineHi, SINE_BAND2, SINE_BAND3, band);
         WAVE_RAMP:
            band = pick_band(period, RAMP_BAND1, RampHi, RAMP_BAND2, RAMP_BAND3, band);
         default:
            band = 2'd0;
      endcase

      idx12 = (idx12 >= 4'd11) ? 4'd0 : idx12 + 4'd1;
      idx16 = idx16 + 4'd1;
      idx2  = ~idx2;

      case (wave_sel)
         WAVE_SINE: begin
            top_p = SineHi; base_p = SineLo; sample = sine_point(idx12);
         end
         WAVE_RAMP: begin
            top_p = RampHi; base_p = RampLo; sample = {idx16, 4'h0};
         end
         WAVE_TRIANGLE: begin
            top_p = SineHi; base_p = SineLo; sample = triangle_point(idx12);
         end
         WAVE_SQUARE: begin
            top_p = SquareHi; base_p = SquareLo; sample = idx2 ? 8'hFF : 8'h00;
         end
         default: begin
            defined = 1'b0;
         end
      endcase

      if (!freq_mode) begin
         amp_lvl = pot;
         level   = pot;
         if (defined && freq_lvl != 8'd0) period = period_for(top_p, base_p, freq_lvl);
      end else begin
         freq_lvl = pot;
         level    = amp_lvl;
         if (defined) period = period_for(top_p, base_p, pot);
      end

      if (!defined)
         res.dac = MIDSCALE;
      else if (sample >= 8'h80)
         res.dac = 8'(128 + (int'(sample) - 128) * int'(level) / 255);
      else
         res.dac = 8'(128 - (128 - int'(sample)) * int'(level) / 255);
      res.period = period;
      res.band   = band;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      tick_result_t want;
      if (reset) begin
         wave_sel  = WAVE_RESET;
         idx12     = '0;
         idx16     = '0;
         idx2      = 1'b0;
         amp_lvl   = '0;
         freq_lvl  = '0;
         freq_mode = 1'b0;
         period    = PERIOD_RESET;
         band      = '0;
         beat_no   = 0;
         pending_ticks.delete();
      end else begin
         if (csr_valid && csr_ready) wave_sel = csr_wave_select;
         if (req_valid && !req_stall)
            pending_ticks.push_back(advance_generator(req_pot, req_sw1_pressed,
                                                      req_sw2_pressed));
         if (rsp_valid && !rsp_stall) begin
            if (pending_ticks.size() == 0) begin
               report_mismatch($sformatf("result beat %0d with nothing expected", beat_no));
            end else begin
               want = pending_ticks.pop_front();
               if (rsp_dac_value !== want.dac)
                  report_mismatch($sformatf("beat %0d dac_value got %0d want %0d",
                                            beat_no, rsp_dac_value, want.dac));
               if (rsp_tick_period !== want.period)
                  report_mismatch($sformatf("beat %0d tick_period got %0d want %0d",
                                            beat_no, rsp_tick_period, want.period));
               if (rsp_filter_band !== want.band)
                  report_mismatch($sformatf("beat %0d filter_band got %0d want %0d",
                                            beat_no, rsp_filter_band, want.band));
            end
            beat_no++;
         end
      end
      outstanding <= pending_ticks.size();
   end

endmodule

// ===== dv/tb_table_waveform_generator.sv =====
// Testbench top for the table waveform generator: clock, reset, beat stimulus and verdict.
// Depends on twg_pkg, table_waveform_generator and twg_tick_checker (prediction and compare).
module tb_table_waveform_generator;

   localparam int RANDOM_ITEMS = 1800;
   localparam int LONG_HOLD    = 150;        // one long result hold-off, in cycles
   localparam int HOLD_AFTER   = 300;        // result beats seen before that hold
   localparam int SETTLE       = 4;          // idle cycles before a register write
   localparam int DRAIN        = 8;          // quiet cycles at the end for stray beats
   localparam int CYCLE_LIMIT  = 1_000_000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_pot;
   logic        req_sw1_pressed;
   logic        req_sw2_pressed;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_dac_value;
   logic [19:0] rsp_tick_period;
   logic [1:0]  rsp_filter_band;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_wave_select;

   int outstanding;
   int mismatches;
   int cycle_count;
   bit tx_calm;      // sender offers back-to-back beats for the whole phase

   table_waveform_generator u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pot         (req_pot),
      .req_sw1_pressed (req_sw1_pressed),
      .req_sw2_pressed (req_sw2_pressed),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_dac_value   (rsp_dac_value),
      .rsp_tick_period (rsp_tick_period),
      .rsp_filter_band (rsp_filter_band),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wave_select (csr_wave_select)
   );

   // Predicts and compares on its own; we only read back how many results are
   // still owed and how many mismatches it has counted.
   twg_tick_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pot         (req_pot),
      .req_sw1_pressed (req_sw1_pressed),
      .req_sw2_pressed (req_sw2_pressed),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_dac_value   (rsp_dac_value),
      .rsp_tick_period (rsp_tick_period),
      .rsp_filter_band (rsp_filter_band),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wave_select (csr_wave_select),
      .outstanding     (outstanding),
      .mismatches      (mismatches)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Watchdog: the slowest legal run stays well under this limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Idle length: mostly none or short, now and then a long gap.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(10, 4);
      return $urandom_range(40, 15);
   endfunction

   // How long the receiver keeps taking beats before it next stalls;
   // the odd long run gives stretches with no stalling at all.
   function automatic int flow_run();
      if ($urandom_range(15) == 0) return $urandom_range(200, 60);
      return $urandom_range(8, 1);
   endfunction

   // Pot readings lean on the corners of the scale now and then.
   function automatic logic [7:0] pick_pot();
      case ($urandom_range(19))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h01;
         3:       return 8'hFE;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Mostly the four real waves; the unused codes get a phase now and then.
   function automatic logic [2:0] pick_wave();
      int r;
      r = $urandom_range(19);
      if (r < 4)  return twg_pkg::WAVE_SINE;
      if (r < 8)  return twg_pkg::WAVE_RAMP;
      if (r < 12) return twg_pkg::WAVE_TRIANGLE;
      if (r < 16) return twg_pkg::WAVE_SQUARE;
      return 3'($urandom_range(7));   // may land on 0, 5, 6 or 7
   endfunction

   // Offer one request beat and hold it until the block takes it. valid stays high
   // afterwards so that the next beat can follow straight on.
   task automatic send_beat(input logic [7:0] pot, input logic sw1, input logic sw2);
      int gap;
      gap = tx_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pot         <= pot;
      req_sw1_pressed <= sw1;
      req_sw2_pressed <= sw2;
      do @(posedge clock); while (req_stall);
   endtask

   // Register writes only while the block is idle: every owed result back,
   // then a few quiet cycles so the pipeline is empty too.
   task automatic change_wave(input logic [2:0] sel);
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_wave_select <= sel;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Receiver: alternating runs of taking and stalling. Once, after enough beats
   // and while a request is on offer, it holds off for a long stretch while the
   // sender keeps offering, so the block fills and has to stall its input.
   initial begin : receiver
      int  run_left;
      int  beats;
      bit  stalling;
      bit  held_long;
      rsp_stall = 1'b0;
      run_left  = 0;
      beats     = 0;
      stalling  = 1'b0;
      held_long = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) beats++;
         if (!held_long && beats >= HOLD_AFTER && req_valid) begin
            held_long = 1'b1;
            stalling  = 1'b1;
            run_left  = LONG_HOLD;
         end
         while (run_left == 0) begin
            stalling = !stalling;
            run_left = stalling ? pick_gap() : flow_run();
         end
         run_left--;
         rsp_stall <= stalling;
      end
   end

   initial begin : stimulus
      int sent;
      int phase_len;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_pot         = '0;
      req_sw1_pressed = 1'b0;
      req_sw2_pressed = 1'b0;
      csr_valid       = 1'b0;
      csr_wave_select = twg_pkg::WAVE_RESET;
      cycle_count     = 0;
      tx_calm         = 1'b0;
      sent            = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // Sine from reset: zero amplitude, full amplitude, then the period extremes.
      // No frequency level yet, so the reset period is held in amplitude mode.
      send_beat(8'h00, 1'b0, 1'b0);
      send_beat(8'hFF, 1'b1, 1'b0);
      send_beat(8'hFF, 1'b0, 1'b1);
      send_beat(8'h00, 1'b0, 1'b1);
      send_beat(8'hAA, 1'b1, 1'b1);    // both pressed: frequency mode wins
      send_beat(8'h55, 1'b0, 1'b0);    // mode held with no switch
      send_beat(8'h01, 1'b1, 1'b0);    // amplitude mode, period from stored level

      // Square at full scale drives the period to its ceiling.
      change_wave(twg_pkg::WAVE_SQUARE);
      send_beat(8'hFF, 1'b0, 1'b1);
      send_beat(8'hFF, 1'b1, 1'b0);
      send_beat(8'h80, 1'b0, 1'b0);

      // Back to sine: the old period sits above every band, so the band is kept.
      change_wave(twg_pkg::WAVE_SINE);
      send_beat(8'h00, 1'b1, 1'b0);

      // Unused wave codes: midscale output, period held, band cleared.
      change_wave(3'd7);
      send_beat(8'h33, 1'b0, 1'b1);
      send_beat(8'hCC, 1'b1, 1'b0);
      change_wave(3'd0);
      send_beat(8'hFF, 1'b0, 1'b0);
      send_beat(8'h00, 1'b0, 1'b1);

      // Ramp down to its period floor, then triangle starting in its own first band.
      change_wave(twg_pkg::WAVE_RAMP);
      send_beat(8'hFF, 1'b1, 1'b0);
      send_beat(8'h00, 1'b0, 1'b1);
      send_beat(8'h10, 1'b0, 1'b0);
      change_wave(twg_pkg::WAVE_TRIANGLE);
      send_beat(8'h00, 1'b0, 1'b0);
      send_beat(8'hFF, 1'b1, 1'b0);
      send_beat(8'hF0, 1'b0, 1'b1);

      // --- random part ---
      // Phases of random length, each with its own wave and sender pacing.
      while (sent < RANDOM_ITEMS) begin
         change_wave(pick_wave());
         tx_calm   = ($urandom_range(3) == 0);
         phase_len = $urandom_range(120, 20);
         for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
            send_beat(pick_pot(), $urandom_range(3) == 0, $urandom_range(3) == 0);
            sent++;
         end
      end

      // Drain: wait for every owed result, then a few more cycles for strays.
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
